[src/sevh_pkg.sv]
`default_nettype none

package sevh_pkg;

  localparam int unsigned CNT_W = 32;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [2:0] {
    ACT_RECORD = 3'd0,
    ACT_CREATE = 3'd1,
    ACT_COUNT  = 3'd2,
    ACT_READ   = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] sample_key;
    logic [5:0]         slot_index;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] key_out;
    logic [31:0]        count_out;
    logic [6:0]         buckets_used;
  } out_t;

  // Broadcast control from the sequencer to every cell of the chain.
  typedef struct packed {
    logic cmp_en;   // register compare and select flags
    logic is_read;  // select by position instead of by key
    logic upd_en;   // apply the update for this item
    logic ins_en;   // insert the broadcast key at its sorted slot
    logic ins_one;  // inserted bucket starts at one, else zero
    logic inc_en;   // add one to the selected bucket, saturating
  } cell_ctl_t;

endpackage

`default_nettype wire

[src/sevh_cell.sv]
`default_nettype none

module sevh_cell import sevh_pkg::*; #(
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned USED_W   = 7,
  parameter int unsigned IDX      = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cell_ctl_t                  ctl_i,
  input  logic signed [KEY_BITS-1:0] key_i,
  input  logic [5:0]                 slot_i,
  input  logic [USED_W-1:0]          used_i,
  input  logic signed [KEY_BITS-1:0] prev_key_i,
  input  logic [CNT_W-1:0]           prev_cnt_i,
  input  logic                       prev_gt_i,
  input  logic                       prev_occ_i,
  output logic signed [KEY_BITS-1:0] key_o,
  output logic [CNT_W-1:0]           cnt_o,
  output logic                       gt_o,
  output logic                       occ_o,
  output logic                       sel_o
);

  logic signed [KEY_BITS-1:0] key_q;
  logic [CNT_W-1:0]           cnt_q;
  logic                       gt_q, sel_q;
  logic                       occ, here;

  assign occ = (32'(used_i) > 32'(IDX));
  // First slot holding a larger key, or the first free slot.
  assign here = (gt_q || !occ) && prev_occ_i && !prev_gt_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gt_q  <= 1'b0;
      sel_q <= 1'b0;
    end else if (ctl_i.cmp_en) begin
      gt_q <= occ && (key_q > key_i);
      if (ctl_i.is_read) begin
        sel_q <= occ && (32'(slot_i) == 32'(IDX));
      end else begin
        sel_q <= occ && (key_q == key_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.upd_en) begin
      if (ctl_i.ins_en) begin
        if (prev_gt_i) begin
          // shift up to make room
          key_q <= prev_key_i;
          cnt_q <= prev_cnt_i;
        end else if (here) begin
          key_q <= key_i;
          cnt_q <= ctl_i.ins_one ? CNT_W'(1) : '0;
        end
      end else if (ctl_i.inc_en && sel_q && (cnt_q != CNT_MAX)) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  assign key_o = key_q;
  assign cnt_o = cnt_q;
  assign gt_o  = gt_q;
  assign occ_o = occ;
  assign sel_o = sel_q;

endmodule

`default_nettype wire

[src/sorted_exact_value_histogram_core.sv]
`default_nettype none

// Sorted exact-value histogram. Buckets live in a chain of MAX_BUCKETS
// cells, kept in ascending signed key order, each with a 32-bit saturating
// count. Every action passes through the transfer in, a compare state
// in which every cell checks its key against the sample (or its position
// against slot_index) in parallel, and an update state in which the chain
// increments, shifts up by one cell to insert, and the result register
// loads. The update state holds while the previous result still waits at
// the output, so a new item may be taken while a result is pending. Keys
// are the low KEY_BITS bits of sample_key, sign-extended; key_out carries
// the low 32 bits of the sign-extended key. Bucket contents are not cleared
// on reset or on a clear action; only the occupancy count is.
module sorted_exact_value_histogram_core import sevh_pkg::*; #(
  parameter int unsigned MAX_BUCKETS = 64,
  parameter int unsigned KEY_BITS    = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam int unsigned USED_W = $clog2(MAX_BUCKETS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_UPD  = 3'b100
  } state_e;

  state_e              state_q, state_d;
  in_t                 item_q;
  logic [USED_W-1:0]   used_q, used_d;
  out_t                out_q, out_d;
  logic                out_valid_q, out_valid_d;
  cell_ctl_t           ctl;
  logic                upd_fire;

  logic signed [63:0]         samp64;
  logic signed [KEY_BITS-1:0] key_b;
  logic signed [63:0]         key64, sel64;

  logic signed [KEY_BITS-1:0] key_vec [MAX_BUCKETS];
  logic [CNT_W-1:0]           cnt_vec [MAX_BUCKETS];
  logic [MAX_BUCKETS-1:0]     gt_vec, occ_vec, sel_vec;

  logic signed [KEY_BITS-1:0] sel_key;
  logic [CNT_W-1:0]           sel_cnt, sel_cnt_inc;
  logic                       hit, full, is_ins_act;
  logic [31:0]                used_ext;

  // Take the key width from the sample, sign-extending where it is wider.
  assign samp64 = 64'(item_q.sample_key);
  assign key_b  = samp64[KEY_BITS-1:0];
  assign key64  = 64'(key_b);

  // Cell chain
  for (genvar g = 0; g < MAX_BUCKETS; g++) begin : g_cell
    logic signed [KEY_BITS-1:0] pk;
    logic [CNT_W-1:0]           pc;
    logic                       pg, po;
    if (g == 0) begin : g_head
      assign pk = '0;
      assign pc = '0;
      assign pg = 1'b0;
      assign po = 1'b1;
    end else begin : g_link
      assign pk = key_vec[g-1];
      assign pc = cnt_vec[g-1];
      assign pg = gt_vec[g-1];
      assign po = occ_vec[g-1];
    end
    sevh_cell #(
      .KEY_BITS(KEY_BITS),
      .USED_W  (USED_W),
      .IDX     (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl),
      .key_i     (key_b),
      .slot_i    (item_q.slot_index),
      .used_i    (used_q),
      .prev_key_i(pk),
      .prev_cnt_i(pc),
      .prev_gt_i (pg),
      .prev_occ_i(po),
      .key_o     (key_vec[g]),
      .cnt_o     (cnt_vec[g]),
      .gt_o      (gt_vec[g]),
      .occ_o     (occ_vec[g]),
      .sel_o     (sel_vec[g])
    );
  end

  // At most one cell is selected: gather its key and count.
  always_comb begin
    sel_key = '0;
    sel_cnt = '0;
    for (int i = 0; i < MAX_BUCKETS; i++) begin
      sel_key = sel_key | (key_vec[i] & {KEY_BITS{sel_vec[i]}});
      sel_cnt = sel_cnt | (cnt_vec[i] & {CNT_W{sel_vec[i]}});
    end
  end

  assign hit         = |sel_vec;
  assign full        = (32'(used_q) >= 32'(MAX_BUCKETS));
  assign sel64       = 64'(sel_key);
  assign sel_cnt_inc = (sel_cnt == CNT_MAX) ? sel_cnt : sel_cnt + CNT_W'(1);
  assign is_ins_act  = (item_q.action == ACT_RECORD) || (item_q.action == ACT_CREATE);

  // Update cycle advances only when the output register is free.
  assign upd_fire = (state_q == ST_UPD) && (!out_valid_q || out_ready_i);

  always_comb begin
    ctl         = '0;
    ctl.cmp_en  = (state_q == ST_CMP);
    ctl.is_read = (item_q.action == ACT_READ);
    ctl.upd_en  = upd_fire;
    ctl.ins_en  = is_ins_act && !hit && !full;
    ctl.ins_one = (item_q.action == ACT_RECORD);
    ctl.inc_en  = (item_q.action == ACT_RECORD);
  end

  // Result and occupancy
  always_comb begin
    used_d            = used_q;
    out_d             = '0;
    out_d.status      = STATUS_OK;
    case (item_q.action)
      ACT_RECORD, ACT_CREATE: begin
        out_d.key_out = key64[31:0];
        if (hit) begin
          out_d.count_out = (item_q.action == ACT_RECORD) ? sel_cnt_inc : sel_cnt;
        end else if (full) begin
          out_d.status = STATUS_FULL;
        end else begin
          out_d.count_out = (item_q.action == ACT_RECORD) ? CNT_W'(1) : '0;
          used_d          = used_q + USED_W'(1);
        end
      end
      ACT_COUNT: begin
        out_d.key_out = key64[31:0];
        if (hit) begin
          out_d.count_out = sel_cnt;
        end else begin
          out_d.status = STATUS_MISS;
        end
      end
      ACT_READ: begin
        if (hit) begin
          out_d.key_out   = sel64[31:0];
          out_d.count_out = sel_cnt;
        end else begin
          out_d.status = STATUS_MISS;
        end
      end
      ACT_CLEAR: begin
        used_d = '0;
      end
      default: begin
      end
    endcase
    used_ext           = 32'(used_d);
    out_d.buckets_used = used_ext[6:0];
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (upd_fire) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (upd_fire) begin
        used_q <= used_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
    if (upd_fire) begin
      out_q <= out_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) <= 32'(MAX_BUCKETS))
    else $error("occupancy exceeds table size");

  a_sel_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(sel_vec))
    else $error("more than one bucket selected");

  a_upd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) && out_valid_q && !out_ready_i |=> (state_q == ST_UPD))
    else $error("update ran over a pending result");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status == STATUS_FULL) |-> full)
    else $error("full status reported with free buckets");

endmodule

`default_nettype wire
